// ===== src/dsf_pkg.sv =====
// Shared types and constants for the duplicate share filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dsf_pkg;
    localparam int BUCKET_W  = 16;
    localparam int NONCE_W   = 32;
    localparam int JOB_W     = 16;
    localparam int TIME_W    = 32;
    localparam int VER_W     = 32;
    localparam int LEAD_W    = 64;
    localparam int TAIL_W    = 32;
    localparam int KEY_W     = 64;
    localparam int ENTRY_W   = KEY_W + VER_W + LEAD_W + TAIL_W;

    typedef enum logic {
        OP_CHECK = 1'b0,
        OP_WIPE  = 1'b1
    } t_op;
endpackage
`default_nettype wire

// ===== src/dsf_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dsf_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/duplicate_share_filter_top.sv =====
// Duplicate share filter: chained hash set, insert if absent.
// Depends on dsf_pkg and dsf_ram.
//
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | operation, nonce, job, time, version, extranonce
// out     | output    | o_out_valid / i_out_ready  | is_duplicate, recorded, table_full
//
// A check reads the bucket head (S_HEAD), then for each chain entry compared reads the RAM
// (S_WALK) and then compares (S_CMP). A miss adds the insert decision (S_INS1), a further
// walk step when the walk runs to the chain end and a link write (S_INS2) when the share is recorded.
// A wipe clears all 65536 bucket heads, one per cycle.
// After reset the same clearing pass runs before the first item is taken.
// Input is taken only in idle; a stalled result holds the finished item, not new input.
`timescale 1ns / 1ps
`default_nettype none
module duplicate_share_filter_top #(
    parameter int CAPACITY = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_operation,
    input  wire logic [dsf_pkg::NONCE_W-1:0]   i_nonce,
    input  wire logic [dsf_pkg::JOB_W-1:0]     i_job_slot,
    input  wire logic [dsf_pkg::TIME_W-1:0]    i_share_time,
    input  wire logic [dsf_pkg::VER_W-1:0]     i_version_word,
    input  wire logic [dsf_pkg::LEAD_W-1:0]    i_extranonce_lead,
    input  wire logic [dsf_pkg::TAIL_W-1:0]    i_extranonce_tail,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_is_duplicate,
    output logic                               o_recorded,
    output logic                               o_table_full
);
    import dsf_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
    localparam logic [BUCKET_W-1:0] LAST_BUCKET = '1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_HEAD, S_WALK, S_CMP, S_INS1, S_INS2, S_RESP
    } t_state;

    t_state                r_state;
    logic                  r_wipe;
    logic [BUCKET_W-1:0]   r_clr;
    logic [BUCKET_W-1:0]   r_bucket;
    logic [KEY_W-1:0]      r_key;
    logic [VER_W-1:0]      r_ver;
    logic [LEAD_W-1:0]     r_lead;
    logic [TAIL_W-1:0]     r_tail;
    logic [LW-1:0]         r_cur;
    logic [LW-1:0]         r_prev;
    logic [LW-1:0]         r_count;
    logic                  r_dup;
    logic                  r_rec;
    logic                  r_out_valid;
    logic                  r_o_dup;
    logic                  r_o_rec;
    logic                  r_o_full;

    // RAM ports
    logic                  head_we;
    logic [BUCKET_W-1:0]   head_waddr;
    logic [LW-1:0]         head_wdata;
    logic [BUCKET_W-1:0]   head_raddr;
    logic [LW-1:0]         head_rdata;
    logic                  ent_we;
    logic [ENTRY_W-1:0]    ent_wdata;
    logic [ENTRY_W-1:0]    ent_rdata;
    logic                  link_we;
    logic [IW-1:0]         link_waddr;
    logic [LW-1:0]         link_wdata;
    logic [LW-1:0]         link_rdata;
    logic [IW-1:0]         rd_idx;
    logic [IW-1:0]         slot;
    logic                  in_acc;
    logic                  full;
    logic                  cur_ok;
    logic                  match;
    logic                  past_key;

    assign in_acc  = i_in_valid && o_in_ready;
    assign full    = (r_count >= CAP_L);
    assign slot    = r_count[IW-1:0];
    assign rd_idx  = IW'(r_cur - LW'(1));
    assign cur_ok  = (r_cur != '0) && (r_cur <= CAP_L);
    assign past_key = ent_rdata[ENTRY_W-1 -: 16] > r_key[KEY_W-1 -: 16];
    assign match   = (ent_rdata == {r_key, r_ver, r_lead, r_tail});

    assign head_raddr = i_nonce[BUCKET_W-1:0];

    always_comb begin
        head_we    = 1'b0;
        head_waddr = r_bucket;
        head_wdata = r_count + LW'(1);
        link_we    = 1'b0;
        link_waddr = slot;
        link_wdata = r_cur;
        ent_we     = 1'b0;
        ent_wdata  = {r_key, r_ver, r_lead, r_tail};
        unique case (r_state)
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_clr;
                head_wdata = '0;
            end
            S_INS1: begin
                ent_we  = !full;
                link_we = !full;
            end
            S_INS2: begin
                if (r_prev == '0) begin
                    head_we = 1'b1;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = IW'(r_prev - LW'(1));
                    link_wdata = r_count + LW'(1);
                end
            end
            default: ;
        endcase
    end

    dsf_ram #(.W(LW), .D(1 << BUCKET_W)) u_heads (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );
    dsf_ram #(.W(ENTRY_W), .D(CAPACITY)) u_entries (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(slot), .i_wdata(ent_wdata),
        .i_raddr(rd_idx), .o_rdata(ent_rdata)
    );
    dsf_ram #(.W(LW), .D(CAPACITY)) u_links (
        .i_clk(i_clk), .i_we(link_we), .i_waddr(link_waddr), .i_wdata(link_wdata),
        .i_raddr(rd_idx), .o_rdata(link_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wipe      <= 1'b0;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_dup       <= 1'b0;
            r_rec       <= 1'b0;
        end else begin
            // S_RESP drives the output slot itself
            if (i_out_ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BUCKET_W'(1);
                    if (r_clr == LAST_BUCKET) begin
                        r_state <= r_wipe ? S_RESP : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_bucket <= i_nonce[BUCKET_W-1:0];
                        r_key    <= {i_nonce[NONCE_W-1:BUCKET_W], i_job_slot, i_share_time};
                        r_ver    <= i_version_word;
                        r_lead   <= i_extranonce_lead;
                        r_tail   <= i_extranonce_tail;
                        r_prev   <= '0;
                        r_dup    <= 1'b0;
                        r_rec    <= 1'b0;
                        if (t_op'(i_operation) == OP_WIPE) begin
                            r_wipe  <= 1'b1;
                            r_clr   <= '0;
                            r_count <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_wipe  <= 1'b0;
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    r_cur   <= head_rdata;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_state <= cur_ok ? S_CMP : S_INS1;
                end
                S_CMP: begin
                    if (past_key) begin
                        r_state <= S_INS1;
                    end else if (match) begin
                        r_dup   <= 1'b1;
                        r_state <= S_RESP;
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= link_rdata;
                        r_state <= S_WALK;
                    end
                end
                S_INS1: begin
                    r_state <= full ? S_RESP : S_INS2;
                end
                S_INS2: begin
                    r_count <= r_count + LW'(1);
                    r_rec   <= 1'b1;
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_dup     <= r_dup;
                        r_o_rec     <= r_rec;
                        r_o_full    <= full;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_is_duplicate = r_o_dup;
    assign o_recorded     = r_o_rec;
    assign o_table_full   = r_o_full;

`ifndef ASSERT_OFF
    a_dup_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_duplicate && o_recorded))
        else $error("duplicate and recorded both set");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_L)
        else $error("entry count above capacity");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after accept");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS2) |-> !full)
        else $error("insert with full store");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for duplicate_share_filter_top: directed rows, then random shares.
// Expected verdicts come from a chained-hash predictor inside the bench. Depends on dsf_pkg.
`timescale 1ns / 1ps
module tb_top;
    import dsf_pkg::*;

    localparam int CAPACITY  = 4096;
    localparam int BUCKETS   = 65536;
    localparam int LIMIT     = 5000000;
    localparam int RAND_ITEMS = 1880;

    typedef struct packed {
        t_op               op;
        logic [NONCE_W-1:0] nonce;
        logic [JOB_W-1:0]   job;
        logic [TIME_W-1:0]  stime;
        logic [VER_W-1:0]   ver;
        logic [LEAD_W-1:0]  lead;
        logic [TAIL_W-1:0]  tail;
    } t_share;

    typedef struct packed {
        logic dup;
        logic rec;
        logic full;
    } t_verdict;

    typedef struct {
        t_share   s;
        bit       typed;
        t_verdict want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_operation = 1'b0;
    logic [NONCE_W-1:0] i_nonce = '0;
    logic [JOB_W-1:0]   i_job_slot = '0;
    logic [TIME_W-1:0]  i_share_time = '0;
    logic [VER_W-1:0]   i_version_word = '0;
    logic [LEAD_W-1:0]  i_extranonce_lead = '0;
    logic [TAIL_W-1:0]  i_extranonce_tail = '0;
    logic i_out_ready = 1'b1;
    logic o_in_ready, o_out_valid, o_is_duplicate, o_recorded, o_table_full;

    duplicate_share_filter_top #(.CAPACITY(CAPACITY)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_operation(i_operation), .i_nonce(i_nonce), .i_job_slot(i_job_slot),
        .i_share_time(i_share_time), .i_version_word(i_version_word),
        .i_extranonce_lead(i_extranonce_lead), .i_extranonce_tail(i_extranonce_tail),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_is_duplicate(o_is_duplicate), .o_recorded(o_recorded),
        .o_table_full(o_table_full)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    int unsigned chain_head [BUCKETS];
    logic [KEY_W-1:0]  slot_key  [CAPACITY];
    logic [VER_W-1:0]  slot_ver  [CAPACITY];
    logic [LEAD_W-1:0] slot_lead [CAPACITY];
    logic [TAIL_W-1:0] slot_tail [CAPACITY];
    int unsigned slot_next [CAPACITY];
    int unsigned stored_count = 0;

    t_verdict pending_verdicts [$];
    t_share   seen_shares [$];
    int mismatches = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int rdy_wait = 0;

    function automatic t_verdict predict_filter(t_share s);
        t_verdict v;
        int unsigned b, cur, prev, idx, steps, pidx;
        logic [KEY_W-1:0] key;
        logic [15:0] hi;
        v = '0;
        if (s.op == OP_WIPE) begin
            for (int i = 0; i < BUCKETS; i++) chain_head[i] = 0;
            stored_count = 0;
            return v;
        end
        b = 32'(s.nonce[15:0]);
        hi = s.nonce[31:16];
        key = {hi, s.job, s.stime};
        prev = 0;
        cur = chain_head[b];
        steps = 0;
        while (cur != 0 && steps < CAPACITY) begin
            idx = cur - 1;
            if (idx >= CAPACITY) break;
            if (slot_key[idx][63:48] > hi) break;
            if (slot_key[idx] == key && slot_ver[idx] == s.ver &&
                slot_lead[idx] == s.lead && slot_tail[idx] == s.tail) begin
                v.dup = 1'b1;
                v.full = (stored_count >= CAPACITY);
                return v;
            end
            prev = cur;
            cur = slot_next[idx];
            steps++;
        end
        if (stored_count >= CAPACITY) begin
            v.full = 1'b1;
            return v;
        end
        idx = stored_count;
        slot_key[idx] = key;
        slot_ver[idx] = s.ver;
        slot_lead[idx] = s.lead;
        slot_tail[idx] = s.tail;
        if (prev == 0) begin
            slot_next[idx] = chain_head[b];
            chain_head[b] = idx + 1;
        end else begin
            pidx = prev - 1;
            slot_next[idx] = slot_next[pidx];
            slot_next[pidx] = idx + 1;
        end
        stored_count = idx + 1;
        v.rec = 1'b1;
        v.full = (stored_count >= CAPACITY);
        return v;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    // one item: optional gap, present, wait for acceptance, log expectation
    task automatic send_share(t_share s, bit typed, t_verdict want);
        int gap;
        t_verdict v;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= s.op;
        i_nonce <= s.nonce;
        i_job_slot <= s.job;
        i_share_time <= s.stime;
        i_version_word <= s.ver;
        i_extranonce_lead <= s.lead;
        i_extranonce_tail <= s.tail;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        v = predict_filter(s);
        pending_verdicts.push_back(typed ? want : v);
        if (s.op == OP_CHECK) begin
            seen_shares.push_back(s);
            if (seen_shares.size() > 600) void'(seen_shares.pop_front());
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
    endtask

    function automatic t_share fresh_share(bit pooled);
        t_share s;
        s.op = OP_CHECK;
        s.nonce = $urandom;
        if (pooled) s.nonce[15:0] = 16'(16'h1111 * $urandom_range(0, 7));
        s.job = 16'($urandom);
        s.stime = $urandom;
        s.ver = $urandom;
        s.lead = {$urandom, $urandom};
        s.tail = $urandom;
        return s;
    endfunction

    function automatic t_share random_share();
        t_share s;
        int r;
        r = $urandom_range(0, 99);
        if (r < 45 && seen_shares.size() > 0) begin
            s = seen_shares[$urandom_range(0, seen_shares.size() - 1)];
            // near miss: one field differs by a single bit
            if (r >= 30) begin
                case ($urandom_range(0, 5))
                    0: s.nonce[31 - $urandom_range(0, 15)] ^= 1'b1;
                    1: s.job[$urandom_range(0, 15)] ^= 1'b1;
                    2: s.stime[$urandom_range(0, 31)] ^= 1'b1;
                    3: s.ver[$urandom_range(0, 31)] ^= 1'b1;
                    4: s.lead[$urandom_range(0, 63)] ^= 1'b1;
                    default: s.tail[$urandom_range(0, 31)] ^= 1'b1;
                endcase
            end
        end else begin
            s = fresh_share($urandom_range(0, 1));
        end
        return s;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_verdict got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_is_duplicate, o_recorded, o_table_full};
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_verdicts.pop_front();
                if (got.dup !== want.dup)
                    report_mismatch($sformatf("is_duplicate %b, want %b", got.dup, want.dup));
                if (got.rec !== want.rec)
                    report_mismatch($sformatf("recorded %b, want %b", got.rec, want.rec));
                if (got.full !== want.full)
                    report_mismatch($sformatf("table_full %b, want %b", got.full, want.full));
            end
        end
    end

    // result-side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rdy_wait = 0;
            i_out_ready <= 1'b1;
        end else begin
            if (o_out_valid && i_out_ready) rdy_wait = quiet ? 0 : $urandom_range(0, 15);
            else if (rdy_wait > 0) rdy_wait--;
            i_out_ready <= (rdy_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_dir_row dir_rows [$];
        t_share zs, os, s;
        t_verdict none;
        int wipes_left;
        none = '0;
        zs = '{OP_CHECK, '0, '0, '0, '0, '0, '0};
        os = '{OP_CHECK, '1, '1, '1, '1, '1, '1};
        for (int i = 0; i < BUCKETS; i++) chain_head[i] = 0;

        dir_rows.push_back('{zs, 1'b1, 3'b010});
        dir_rows.push_back('{zs, 1'b1, 3'b100});
        dir_rows.push_back('{os, 1'b1, 3'b010});
        dir_rows.push_back('{os, 1'b1, 3'b100});
        s = zs; s.nonce = 32'h0001_0000;  dir_rows.push_back('{s, 1'b0, none});
        s = zs; s.job = 16'h0001;         dir_rows.push_back('{s, 1'b0, none});
        s = zs; s.stime = 32'h1;          dir_rows.push_back('{s, 1'b0, none});
        s = zs; s.ver = 32'h1;            dir_rows.push_back('{s, 1'b0, none});
        s = zs; s.lead = 64'h8000_0000_0000_0000; dir_rows.push_back('{s, 1'b0, none});
        s = zs; s.tail = 32'h8000_0000;   dir_rows.push_back('{s, 1'b0, none});
        // max sort key, then an equal sort key landing after existing ones, then a repeat
        s = zs; s.nonce = 32'hFFFF_0000;  dir_rows.push_back('{s, 1'b0, none});
        s = zs; s.nonce = 32'h0001_0000;  s.job = 16'hFFFF; dir_rows.push_back('{s, 1'b0, none});
        s = zs; s.nonce = 32'h0001_0000;  dir_rows.push_back('{s, 1'b0, none});
        s = zs; s.op = OP_WIPE;           dir_rows.push_back('{s, 1'b1, 3'b000});
        dir_rows.push_back('{zs, 1'b1, 3'b010});
        dir_rows.push_back('{os, 1'b1, 3'b010});
        s = os; s.op = OP_WIPE;           dir_rows.push_back('{s, 1'b1, 3'b000});
        dir_rows.push_back('{os, 1'b1, 3'b010});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_share(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        wipes_left = 2;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            quiet = ((n / 150) % 4 == 3);
            if (n % 400 == 399) drain_results();
            if (wipes_left > 0 && $urandom_range(0, 599) == 0) begin
                s = fresh_share(1'b0);
                s.op = OP_WIPE;
                wipes_left--;
            end else begin
                s = random_share();
            end
            send_share(s, 1'b0, none);
        end

        // repeats mixed with fresh shares, then a wipe and a short refill
        quiet = 1'b0;
        for (int n = 0; n < 20; n++) begin
            if (n % 2 == 0) s = seen_shares[$urandom_range(0, seen_shares.size() - 1)];
            else s = fresh_share($urandom_range(0, 1));
            send_share(s, 1'b0, none);
        end
        s = zs; s.op = OP_WIPE;
        send_share(s, 1'b1, 3'b000);
        for (int n = 0; n < 30; n++) send_share(random_share(), 1'b0, none);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
